// ----- design/rmt_pkg.sv -----
package rmt_pkg;

	localparam int COLUMNS = 32;
	localparam int COL_W = 5;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_EMIT    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// One queued command word.
	typedef struct packed {
		op_t  op;
		logic sys_bit;
		logic par1_bit;
		logic par2_bit;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD_ADDR,
		ST_WR_SYS,
		ST_WR_PAR1,
		ST_WR_PAR2,
		ST_EMIT_START,
		ST_MOD,
		ST_SPLIT,
		ST_SCAN,
		ST_RESP
	} eng_state_t;

	localparam logic [1:0] CFG_TRIPLES = 2'd0;
	localparam logic [1:0] CFG_OUT_LEN = 2'd1;
	localparam logic [1:0] CFG_RV      = 2'd2;

	// Bit-reversed column permutation of the 32-column interleaver.
	function automatic logic [COL_W-1:0] col_perm(input logic [COL_W-1:0] c);
		col_perm = {c[0], c[1], c[2], c[3], c[4]};
	endfunction

endpackage

// ----- design/turbo_rate_match_tx.sv -----
// LTE turbo rate matcher with a circular buffer.
// Commands enter on start with op, sys_bit, par1_bit and par2_bit; a word is
// taken at a rising edge where start is high and busy is low. A load word
// writes one coded triple into the interleaved buffer, an emit word returns
// the next selected bit, a restart word rewinds the selection to its start
// point. Op code 3 is taken and dropped.
// Accepted words wait in a two-entry command queue; busy is high only while
// that queue is full, so the sender can run ahead of the engine behind it.
// A load passes through the engine as a dequeue, an address step, then three
// writes through the one write port of the bit memory. An emit passes through
// dequeue, start, scan and response, scanning on past each skipped dummy
// position; right after a triple_count change the first continuing emit also
// reduces its position before the scan.
// Each result shows out_bit and last for exactly one cycle with out_valid;
// the receiver cannot stall, so results are never held.
// Configuration words on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is high) and must only be sent while the block is idle.
// Reset clears the queue, the counters and the registers to triple_count 1,
// output_length 1, redundancy_version 0; buffer contents start undefined.
module turbo_rate_match_tx #(
	parameter int MAX_ROWS = 193
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic        sys_bit,
	input  logic        par1_bit,
	input  logic        par2_bit,
	output logic        out_valid,
	output logic        out_bit,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int RW        = $clog2(MAX_ROWS + 1);
	localparam int MAX_TRIPS = MAX_ROWS * rmt_pkg::COLUMNS;

	rmt_pkg::cmd_t in_cmd, head_cmd;
	logic          head_valid, pop, cfg_we;
	logic [12:0]   trip_raw, trip_eff, triples_q;
	logic [RW-1:0] rows_n, rows_q;
	logic [4:0]    dummy_n, dummy_q;
	logic [15:0]   out_len_q;
	logic [1:0]    rv_q;
	logic          geo_change;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Geometry: rows = ceil(triples / 32), dummies pad the first row.
	assign trip_raw = cfg_data[12:0];
	always_comb begin
		if (trip_raw == 13'd0)                  trip_eff = 13'd1;
		else if (trip_raw > 13'(MAX_TRIPS))     trip_eff = 13'(MAX_TRIPS);
		else                                    trip_eff = trip_raw;
	end
	assign rows_n     = RW'(((trip_eff - 13'd1) >> rmt_pkg::COL_W) + 13'd1);
	assign dummy_n    = 5'(6'd32 - {1'b0, trip_eff[4:0]});
	assign geo_change = cfg_we && (cfg_index == rmt_pkg::CFG_TRIPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			triples_q <= 13'd1;
			rows_q    <= RW'(1);
			dummy_q   <= 5'd31;
			out_len_q <= 16'd1;
			rv_q      <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				rmt_pkg::CFG_TRIPLES: begin
					triples_q <= trip_eff;
					rows_q    <= rows_n;
					dummy_q   <= dummy_n;
				end
				rmt_pkg::CFG_OUT_LEN: out_len_q <= cfg_data;
				rmt_pkg::CFG_RV:      rv_q      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign in_cmd = '{op: rmt_pkg::op_t'(op), sys_bit: sys_bit, par1_bit: par1_bit,
		par2_bit: par2_bit};

	rmt_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (start && !busy),
		.push_cmd   (in_cmd),
		.pop        (pop),
		.full       (busy),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	rmt_engine #(.MAX_ROWS(MAX_ROWS)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rows       (rows_q),
		.dummy      (dummy_q),
		.triples    (triples_q),
		.out_len    (out_len_q),
		.rv         (rv_q),
		.geo_change (geo_change),
		.res_valid  (out_valid),
		.res_bit    (out_bit),
		.res_last   (last)
	);

	// A result needs at least a dequeue, a scan and a response cycle.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |=> !out_valid)
		else $error("results on consecutive cycles");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !pop)
		else $error("command dequeued while a result is shown");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !pop) |=> busy)
		else $error("queue lost a word without a dequeue");

endmodule

// ----- design/rmt_cmd_queue.sv -----
module rmt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rmt_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output rmt_pkg::cmd_t head_cmd
);

	rmt_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	// Unused op codes are dropped here, so the back end only sees real work.
	assign do_push    = push && (count_q != 2'd2) && (push_cmd.op != rmt_pkg::OP_NONE);
	assign do_pop     = pop && (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ----- design/rmt_engine.sv -----
module rmt_engine #(
	parameter int MAX_ROWS = 193
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               head_valid,
	input  rmt_pkg::cmd_t                      head_cmd,
	output logic                               pop,
	input  logic [$clog2(MAX_ROWS+1)-1:0]      rows,
	input  logic [4:0]                         dummy,
	input  logic [12:0]                        triples,
	input  logic [15:0]                        out_len,
	input  logic [1:0]                         rv,
	input  logic                               geo_change,
	output logic                               res_valid,
	output logic                               res_bit,
	output logic                               res_last
);

	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int DEPTH = 3 * MAX_ROWS * rmt_pkg::COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = RW + rmt_pkg::COL_W;

	rmt_pkg::eng_state_t state_q, state_d;
	rmt_pkg::cmd_t       cmd_q;

	logic              mem [DEPTH];
	logic              rd_bit_q;
	logic              we;
	logic [AW-1:0]     waddr;
	logic              wbit;

	logic [12:0]       load_idx_q;
	logic [AW-1:0]     a_q, b_q;
	logic [AW-1:0]     x_q, m_q;
	logic [4:0]        col_q;
	logic [RW-1:0]     row_q;
	logic              par_q, sub_q, stale_q;
	logic              stale_clr;
	logic [15:0]       emitted_q;
	logic              last_q;

	logic [AW-1:0]     kp, ncb, k0;
	logic [6:0]        k0_mul;
	logic [4:0]        k0_col;
	logic              k0_par;
	logic [12:0]       idx_eff;
	logic [AW-1:0]     p, q, a_n, b_n;
	logic [NW-1:0]     nat, nat1;
	logic              is_dummy;
	logic              row_last, m_wrap;
	logic [4:0]        nx_col;
	logic [RW-1:0]     nx_row;
	logic              nx_par, nx_sub;
	logic [AW-1:0]     nx_x;
	logic [16:0]       done_cnt;
	logic              hit_last;

	assign kp  = AW'(rows) << rmt_pkg::COL_W;
	assign ncb = kp + (kp << 1);

	// Start point: 2, 26, 50 or 74 rows; the last two land in the parity area.
	always_comb begin
		case (rv)
			2'd0:    begin k0_mul = 7'd2;  k0_col = 5'd2;  k0_par = 1'b0; end
			2'd1:    begin k0_mul = 7'd26; k0_col = 5'd26; k0_par = 1'b0; end
			2'd2:    begin k0_mul = 7'd50; k0_col = 5'd9;  k0_par = 1'b1; end
			default: begin k0_mul = 7'd74; k0_col = 5'd21; k0_par = 1'b1; end
		endcase
	end
	assign k0 = AW'(rows) * AW'(k0_mul);

	// Load addresses.
	assign idx_eff = (load_idx_q >= triples) ? 13'd0 : load_idx_q;
	assign p   = AW'(idx_eff) + AW'(dummy);
	assign q   = (p == '0) ? kp - AW'(1) : p - AW'(1);
	assign a_n = AW'(rmt_pkg::col_perm(p[4:0])) * AW'(rows) + (p >> rmt_pkg::COL_W);
	assign b_n = AW'(rmt_pkg::col_perm(q[4:0])) * AW'(rows) + (q >> rmt_pkg::COL_W);

	// Dummy test of the current position from its row and column.
	assign nat  = {row_q, rmt_pkg::col_perm(col_q)};
	assign nat1 = nat + NW'(1);
	always_comb begin
		if (par_q && sub_q) begin
			if (AW'(nat1) == kp) is_dummy = (dummy != 5'd0);
			else                 is_dummy = (nat1 < NW'(dummy));
		end else begin
			is_dummy = (nat < NW'(dummy));
		end
	end

	// One step along the circular buffer.
	assign row_last = (row_q == rows - RW'(1));
	assign m_wrap   = row_last && (col_q == 5'd31);
	always_comb begin
		nx_col = col_q;
		nx_row = row_q;
		nx_par = par_q;
		nx_sub = sub_q;
		nx_x   = (x_q + AW'(1) == ncb) ? '0 : x_q + AW'(1);
		if (!par_q || sub_q) begin
			nx_sub = 1'b0;
			if (m_wrap) begin
				nx_col = '0;
				nx_row = '0;
				nx_par = ~par_q;
			end else if (row_last) begin
				nx_row = '0;
				nx_col = col_q + 5'd1;
			end else begin
				nx_row = row_q + RW'(1);
			end
		end else begin
			nx_sub = 1'b1;
		end
	end

	assign done_cnt = {1'b0, emitted_q} + 17'd1;
	assign hit_last = (done_cnt >= {1'b0, out_len});

	// The position is current again after a restart, a finished split or a found bit.
	assign stale_clr = ((state_q == rmt_pkg::ST_IDLE) && head_valid &&
			(head_cmd.op == rmt_pkg::OP_RESTART))
		|| ((state_q == rmt_pkg::ST_SPLIT) && (m_q < AW'(rows)))
		|| ((state_q == rmt_pkg::ST_SCAN) && !is_dummy);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rmt_pkg::ST_IDLE: begin
				if (head_valid) begin
					unique case (head_cmd.op)
						rmt_pkg::OP_LOAD: state_d = rmt_pkg::ST_LOAD_ADDR;
						rmt_pkg::OP_EMIT: state_d = rmt_pkg::ST_EMIT_START;
						default:          state_d = rmt_pkg::ST_IDLE;
					endcase
				end
			end
			rmt_pkg::ST_LOAD_ADDR: state_d = rmt_pkg::ST_WR_SYS;
			rmt_pkg::ST_WR_SYS:    state_d = rmt_pkg::ST_WR_PAR1;
			rmt_pkg::ST_WR_PAR1:   state_d = rmt_pkg::ST_WR_PAR2;
			rmt_pkg::ST_WR_PAR2:   state_d = rmt_pkg::ST_IDLE;
			rmt_pkg::ST_EMIT_START: begin
				if (emitted_q == 16'd0 || !stale_q) state_d = rmt_pkg::ST_SCAN;
				else                                state_d = rmt_pkg::ST_MOD;
			end
			rmt_pkg::ST_MOD:   if (x_q < ncb) state_d = rmt_pkg::ST_SPLIT;
			rmt_pkg::ST_SPLIT: if (m_q < AW'(rows)) state_d = rmt_pkg::ST_SCAN;
			rmt_pkg::ST_SCAN:  if (!is_dummy) state_d = rmt_pkg::ST_RESP;
			rmt_pkg::ST_RESP:  state_d = rmt_pkg::ST_IDLE;
			default:           state_d = rmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == rmt_pkg::ST_IDLE) && head_valid;
		res_valid = (state_q == rmt_pkg::ST_RESP);
		we        = 1'b0;
		waddr     = a_q;
		wbit      = cmd_q.sys_bit;
		unique case (state_q)
			rmt_pkg::ST_WR_SYS: we = 1'b1;
			rmt_pkg::ST_WR_PAR1: begin
				we    = 1'b1;
				waddr = kp + (a_q << 1);
				wbit  = cmd_q.par1_bit;
			end
			rmt_pkg::ST_WR_PAR2: begin
				we    = 1'b1;
				waddr = kp + (b_q << 1) + AW'(1);
				wbit  = cmd_q.par2_bit;
			end
			default: ;
		endcase
	end
	assign res_bit  = rd_bit_q;
	assign res_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rmt_pkg::ST_IDLE;
			load_idx_q <= '0;
			x_q        <= '0;
			col_q      <= '0;
			row_q      <= '0;
			par_q      <= 1'b0;
			sub_q      <= 1'b0;
			stale_q    <= 1'b0;
			emitted_q  <= '0;
		end else begin
			state_q <= state_d;
			if (stale_clr)       stale_q <= 1'b0;
			else if (geo_change) stale_q <= 1'b1;
			unique case (state_q)
				rmt_pkg::ST_IDLE: begin
					if (head_valid && head_cmd.op == rmt_pkg::OP_RESTART) begin
						emitted_q <= '0;
						x_q       <= '0;
						col_q     <= '0;
						row_q     <= '0;
						par_q     <= 1'b0;
						sub_q     <= 1'b0;
					end
				end
				rmt_pkg::ST_LOAD_ADDR: begin
					load_idx_q <= (idx_eff + 13'd1 >= triples) ? 13'd0 : idx_eff + 13'd1;
				end
				rmt_pkg::ST_EMIT_START: begin
					if (emitted_q == 16'd0) begin
						x_q   <= k0;
						col_q <= k0_col;
						row_q <= '0;
						par_q <= k0_par;
						sub_q <= 1'b0;
					end
				end
				rmt_pkg::ST_MOD: begin
					if (x_q >= ncb) begin
						x_q <= x_q - ncb;
					end else begin
						col_q <= '0;
						if (x_q < kp) begin
							par_q <= 1'b0;
							sub_q <= 1'b0;
						end else begin
							par_q <= 1'b1;
							sub_q <= x_q[0] ^ kp[0];
						end
					end
				end
				rmt_pkg::ST_SPLIT: begin
					if (m_q >= AW'(rows)) begin
						col_q <= col_q + 5'd1;
					end else begin
						row_q <= RW'(m_q);
					end
				end
				rmt_pkg::ST_SCAN: begin
					x_q   <= nx_x;
					col_q <= nx_col;
					row_q <= nx_row;
					par_q <= nx_par;
					sub_q <= nx_sub;
					if (!is_dummy) begin
						emitted_q <= hit_last ? 16'd0 : done_cnt[15:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head_cmd;
		if (state_q == rmt_pkg::ST_LOAD_ADDR) begin
			a_q <= a_n;
			b_q <= b_n;
		end
		if (state_q == rmt_pkg::ST_MOD) begin
			if (x_q < kp) m_q <= x_q;
			else          m_q <= (x_q - kp) >> 1;
		end
		if (state_q == rmt_pkg::ST_SPLIT && m_q >= AW'(rows)) m_q <= m_q - AW'(rows);
		if (state_q == rmt_pkg::ST_SCAN && !is_dummy) last_q <= hit_last;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wbit;
		if (state_q == rmt_pkg::ST_SCAN) rd_bit_q <= mem[x_q];
	end

endmodule
